// File: rtl/ppd_pkg.sv
// Shared constants, codes and command/status types for the task dispatcher.
package ppd_pkg;

  localparam int TaskSlots = 16;
  localparam int PriorityLevels = 4;
  localparam int IdW = $clog2(TaskSlots);
  localparam int CntW = $clog2(TaskSlots + 1);
  localparam int PrioW = 2;
  localparam int PcurW = $clog2(PriorityLevels + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_ENABLE = 3'd1;
  localparam logic [2:0] OP_FULL = 3'd2;
  localparam logic [2:0] OP_CRIT = 3'd3;
  localparam logic [2:0] OP_DONE = 3'd4;
  localparam logic [2:0] OP_READ = 3'd5;

  localparam logic [2:0] K_RUN = 3'd0;
  localparam logic [2:0] K_FULL_DONE = 3'd1;
  localparam logic [2:0] K_CRIT_DONE = 3'd2;
  localparam logic [2:0] K_REFUSED = 3'd3;
  localparam logic [2:0] K_ADDED = 3'd4;
  localparam logic [2:0] K_ADD_REJ = 3'd5;
  localparam logic [2:0] K_DURATION = 3'd6;
  localparam logic [2:0] K_ACK = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;       // write a new entry at task_count
    logic enable;    // write the enable bit
    logic finish;    // store now and duration at the cursor entry
    logic set_full_now;
    logic set_crit_now;
    logic [IdW-1:0] scan_idx;
  } ppd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [PrioW-1:0] prio;
    logic due_full;
    logic due_crit;
  } ppd_stat_t;

endpackage

// File: rtl/ppd_datapath.sv
// Task table and due-time comparison for the dispatcher.
module ppd_datapath (
  input  logic clk,
  input  logic rst,
  input  ppd_pkg::ppd_cmd_t cmd,
  input  logic [ppd_pkg::IdW-1:0] cur_idx,
  input  logic [ppd_pkg::PrioW-1:0] in_prio,
  input  logic [15:0] in_interval,
  input  logic in_enable,
  input  logic [ppd_pkg::IdW-1:0] in_id,
  input  logic [31:0] in_now,
  input  logic [31:0] in_dur,
  output ppd_pkg::ppd_stat_t stat,
  output logic [31:0] dur_rd
);
  logic [ppd_pkg::PrioW-1:0] task_prio [ppd_pkg::TaskSlots];
  logic [15:0] task_interval [ppd_pkg::TaskSlots];
  logic [31:0] task_last_run [ppd_pkg::TaskSlots];
  logic [31:0] task_duration [ppd_pkg::TaskSlots];
  logic [ppd_pkg::TaskSlots-1:0] task_enabled;
  logic [ppd_pkg::CntW-1:0] count;
  logic [31:0] full_now;
  logic [31:0] crit_now;
  logic [31:0] dfull;
  logic [31:0] dcrit;
  logic [ppd_pkg::IdW-1:0] k;

  assign k = count[ppd_pkg::IdW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      task_enabled <= '0;
      for (int i = 0; i < ppd_pkg::TaskSlots; i++) begin
        task_prio[i] <= '0;
        task_interval[i] <= '0;
        task_last_run[i] <= '0;
        task_duration[i] <= '0;
      end
      full_now <= '0;
      crit_now <= '0;
    end else begin
      if (cmd.add) begin
        task_prio[k] <= in_prio;
        task_interval[k] <= in_interval;
        task_last_run[k] <= '0;
        task_duration[k] <= '0;
        task_enabled[k] <= 1'b1;
        count <= count + 1'b1;
      end
      if (cmd.enable) begin
        task_enabled[in_id] <= in_enable;
      end
      if (cmd.finish) begin
        task_last_run[cur_idx] <= in_now;
        task_duration[cur_idx] <= in_dur;
      end
      if (cmd.set_full_now) begin
        full_now <= in_now;
      end
      if (cmd.set_crit_now) begin
        crit_now <= in_now;
      end
    end
  end

  assign dfull = full_now - task_last_run[cmd.scan_idx];
  assign dcrit = crit_now - task_last_run[cmd.scan_idx];

  always_comb begin
    stat.count = count;
    stat.prio = task_prio[cmd.scan_idx];
    stat.due_full = task_enabled[cmd.scan_idx] &&
      ((task_interval[cmd.scan_idx] == 16'd0) || (dfull >= {16'd0, task_interval[cmd.scan_idx]}));
    stat.due_crit = task_enabled[cmd.scan_idx] &&
      ((task_interval[cmd.scan_idx] == 16'd0) || (dcrit >= {16'd0, task_interval[cmd.scan_idx]}));
  end

  assign dur_rd = task_duration[in_id];
endmodule

// File: rtl/ppd_control.sv
// Opcode decoder and pass scanner state machine for the dispatcher.
module ppd_control (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] opcode,
  input  logic [ppd_pkg::IdW-1:0] in_id,
  output ppd_pkg::ppd_cmd_t cmd,
  output logic [ppd_pkg::IdW-1:0] cur_idx,
  input  ppd_pkg::ppd_stat_t stat,
  input  logic [31:0] dur_rd,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] kind,
  output logic [ppd_pkg::IdW-1:0] task_id_res,
  output logic [31:0] duration_us_res,
  output logic did_work
);
  typedef enum logic [1:0] {S_IDLE, S_FULL, S_CRIT} state_t;

  localparam int ScanW = ppd_pkg::IdW + 1;

  state_t state;
  logic full_active;
  logic crit_active;
  logic crit_did_work;
  logic [ppd_pkg::PcurW-1:0] fprio;
  logic [ScanW-1:0] fidx;   // one past the task handed out, then scan position
  logic [ScanW-1:0] cidx;
  logic [ScanW-1:0] scan;
  logic accept;
  logic out_free;
  logic in_range;
  logic [ScanW-1:0] n;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;
  assign in_range = ({1'b0, in_id} < ScanW'(stat.count));
  assign n = ScanW'(stat.count);
  assign cur_idx = crit_active ? cidx[ppd_pkg::IdW-1:0] - 1'b1 : fidx[ppd_pkg::IdW-1:0] - 1'b1;

  always_comb begin
    cmd.scan_idx = scan[ppd_pkg::IdW-1:0];
    cmd.add = accept && opcode == ppd_pkg::OP_ADD && stat.count < ppd_pkg::CntW'(ppd_pkg::TaskSlots);
    cmd.enable = accept && opcode == ppd_pkg::OP_ENABLE && in_range;
    cmd.finish = accept && opcode == ppd_pkg::OP_DONE && (crit_active || full_active) &&
      ((crit_active ? cidx : fidx) != '0);
    cmd.set_full_now = accept && ((opcode == ppd_pkg::OP_FULL && !full_active) ||
      (opcode == ppd_pkg::OP_DONE && !crit_active && full_active));
    cmd.set_crit_now = accept && ((opcode == ppd_pkg::OP_CRIT && !crit_active) ||
      (opcode == ppd_pkg::OP_DONE && crit_active));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full_active <= 1'b0;
      crit_active <= 1'b0;
      crit_did_work <= 1'b0;
      fprio <= '0;
      fidx <= '0;
      cidx <= '0;
      scan <= '0;
      out_valid <= 1'b0;
      kind <= ppd_pkg::K_ACK;
      task_id_res <= '0;
      duration_us_res <= '0;
      did_work <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            task_id_res <= '0;
            duration_us_res <= '0;
            did_work <= 1'b0;
            case (opcode)
              ppd_pkg::OP_ADD: begin
                out_valid <= 1'b1;
                if (cmd.add) begin
                  kind <= ppd_pkg::K_ADDED;
                  task_id_res <= stat.count[ppd_pkg::IdW-1:0];
                end else begin
                  kind <= ppd_pkg::K_ADD_REJ;
                end
              end
              ppd_pkg::OP_FULL: begin
                if (full_active) begin
                  out_valid <= 1'b1;
                  kind <= ppd_pkg::K_REFUSED;
                end else begin
                  full_active <= 1'b1;
                  fprio <= '0;
                  fidx <= '0;
                  scan <= '0;
                  state <= S_FULL;
                end
              end
              ppd_pkg::OP_CRIT: begin
                if (crit_active) begin
                  out_valid <= 1'b1;
                  kind <= ppd_pkg::K_REFUSED;
                end else begin
                  crit_active <= 1'b1;
                  crit_did_work <= 1'b0;
                  cidx <= '0;
                  scan <= '0;
                  state <= S_CRIT;
                end
              end
              ppd_pkg::OP_DONE: begin
                if (crit_active) begin
                  scan <= cidx;
                  state <= S_CRIT;
                end else if (full_active) begin
                  scan <= fidx;
                  state <= S_FULL;
                end else begin
                  out_valid <= 1'b1;
                  kind <= ppd_pkg::K_ACK;
                end
              end
              ppd_pkg::OP_READ: begin
                out_valid <= 1'b1;
                kind <= ppd_pkg::K_DURATION;
                duration_us_res <= in_range ? dur_rd : 32'd0;
              end
              default: begin
                out_valid <= 1'b1;
                kind <= ppd_pkg::K_ACK;
              end
            endcase
          end
        end
        // One entry is examined per cycle.
        S_FULL: begin
          if (fprio >= ppd_pkg::PcurW'(ppd_pkg::PriorityLevels)) begin
            full_active <= 1'b0;
            fprio <= '0;
            fidx <= '0;
            out_valid <= 1'b1;
            kind <= ppd_pkg::K_FULL_DONE;
            state <= S_IDLE;
          end else if (scan >= n) begin
            fprio <= fprio + 1'b1;
            scan <= '0;
          end else if (ppd_pkg::PcurW'(stat.prio) == fprio && stat.due_full) begin
            fidx <= scan + 1'b1;
            out_valid <= 1'b1;
            kind <= ppd_pkg::K_RUN;
            task_id_res <= scan[ppd_pkg::IdW-1:0];
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_CRIT: begin
          if (scan >= n) begin
            crit_active <= 1'b0;
            out_valid <= 1'b1;
            kind <= ppd_pkg::K_CRIT_DONE;
            did_work <= crit_did_work;
            state <= S_IDLE;
          end else if (stat.prio == '0 && stat.due_crit) begin
            cidx <= scan + 1'b1;
            crit_did_work <= 1'b1;
            out_valid <= 1'b1;
            kind <= ppd_pkg::K_RUN;
            task_id_res <= scan[ppd_pkg::IdW-1:0];
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/priority_periodic_task_dispatcher.sv
// Top level of the priority periodic task dispatcher.
// Table operations give their registered result in the cycle after the transfer.
// A pass step, full or critical, examines one table entry per cycle.
// One item is in work at a time. Synchronous reset clears the whole table at once.
module priority_periodic_task_dispatcher (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] opcode,
  input  logic [3:0] task_id,
  input  logic [1:0] priority_req,
  input  logic [15:0] interval_ms,
  input  logic enable_flag,
  input  logic [31:0] now_ms,
  input  logic [31:0] duration_us,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] kind,
  output logic [3:0] task_id_res,
  output logic [31:0] duration_us_res,
  output logic did_work
);
  ppd_pkg::ppd_cmd_t cmd;
  ppd_pkg::ppd_stat_t stat;
  logic [ppd_pkg::IdW-1:0] cur_idx;
  logic [31:0] dur_rd;

  ppd_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .in_id(task_id), .cmd(cmd), .cur_idx(cur_idx),
    .stat(stat), .dur_rd(dur_rd), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .task_id_res(task_id_res), .duration_us_res(duration_us_res),
    .did_work(did_work)
  );

  ppd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cur_idx(cur_idx), .in_prio(priority_req),
    .in_interval(interval_ms), .in_enable(enable_flag), .in_id(task_id),
    .in_now(now_ms), .in_dur(duration_us), .stat(stat), .dur_rd(dur_rd)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !(in_valid && !in_stall) || out_valid || in_stall)
    else $error("transfer overlap");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= ppd_pkg::CntW'(ppd_pkg::TaskSlots))
    else $error("task count overflow");
  a_did_work_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_work |-> kind == ppd_pkg::K_CRIT_DONE)
    else $error("did_work outside critical done");
endmodule
